FILE: rtl/stack_machine_executor_macros.svh
// Assertion macros used by the checker module.
// Each takes a label, an antecedent, a consequent and a message string.
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// consequent must hold in the same cycle
`define SME_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sme_pkg.sv
package sme_pkg;

  // widths
  localparam int DATA_W    = 32;
  localparam int OP_W      = 7;
  localparam int ST_W      = 3;
  localparam int DEPTH_W   = 9;
  localparam int EN_W      = 8;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  localparam int STACK_DEPTH_DEF = 256;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 7'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 7'd2;
  localparam logic [OP_W-1:0] OP_SUB  = 7'd3;
  localparam logic [OP_W-1:0] OP_MUL  = 7'd4;
  localparam logic [OP_W-1:0] OP_DIV  = 7'd5;
  localparam logic [OP_W-1:0] OP_PEEK = 7'd6;
  localparam logic [OP_W-1:0] OP_HALT = 7'd7;
  localparam logic [OP_W-1:0] OP_SQR  = 7'd100;

  // enable bit positions in op_enable
  localparam int EN_PUSH   = 0;
  localparam int EN_ADD    = 1;
  localparam int EN_SUB    = 2;
  localparam int EN_MUL    = 3;
  localparam int EN_DIV    = 4;
  localparam int EN_PRINT  = 5;
  localparam int EN_HALT   = 6;
  localparam int EN_SQUARE = 7;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_OVER  = 3'd1;
  localparam logic [ST_W-1:0] ST_UNDER = 3'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [ST_W-1:0] ST_BADOP = 3'd4;
  localparam logic [ST_W-1:0] ST_STOP  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ARITH,
    S_DIV,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    K_BAD,
    K_PUSH,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_PRINT,
    K_HALT,
    K_SQUARE
  } kind_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  // opcode to instruction kind; disabled or unknown opcodes give K_BAD
  function automatic kind_t op_decode(input logic [OP_W-1:0] op,
                                      input logic [EN_W-1:0] en);
    kind_t k;
    k = K_BAD;
    case (op)
      OP_PUSH: if (en[EN_PUSH])   k = K_PUSH;
      OP_ADD:  if (en[EN_ADD])    k = K_ADD;
      OP_SUB:  if (en[EN_SUB])    k = K_SUB;
      OP_MUL:  if (en[EN_MUL])    k = K_MUL;
      OP_DIV:  if (en[EN_DIV])    k = K_DIV;
      OP_PEEK: if (en[EN_PRINT])  k = K_PRINT;
      OP_HALT: if (en[EN_HALT])   k = K_HALT;
      OP_SQR:  if (en[EN_SQUARE]) k = K_SQUARE;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/sme_div.sv
// Radix-2 restoring divider, signed operands, quotient truncated toward zero.
// One quotient bit per cycle; done pulses as the last bit is registered.
module sme_div (
  input  logic              clk,
  input  logic              rst,
  input  sme_pkg::div_req_t req,
  output sme_pkg::div_rsp_t rsp
);

  localparam int W  = sme_pkg::DATA_W;
  localparam int CW = $clog2(W + 1);

  logic          run;
  logic          done;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  den;

  logic          a_neg;
  logic          b_neg;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  // operand magnitudes
  assign a_neg = req.dividend[W-1];
  assign b_neg = req.divisor[W-1];
  assign a_mag = a_neg ? ('0 - req.dividend) : req.dividend;
  assign b_mag = b_neg ? ('0 - req.divisor) : req.divisor;

  // trial subtract
  assign shifted = {rem, quo[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= a_mag;
      den <= b_mag;
      neg <= a_neg ^ b_neg;
    end else if (run) begin
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? ('0 - quo) : quo;

endmodule

FILE: rtl/stack_machine_executor.sv
// Stack machine executor: each input beat is one instruction (push, add, sub,
// mul, div, square, print, halt) on a STACK_DEPTH x 32-bit stack held in a
// synchronous RAM with one write port and one registered read port, the top
// entry mirrored in a register. Exactly one result beat per instruction,
// carrying status, top of stack, depth, a print flag and the halted flag. One
// instruction is in flight at a time: push, print, halt, square, rejected
// items and underflows pass the check and finish states; add, sub and mul
// also pass the arith state (second operand from RAM, registered multiply),
// and div then waits in the div state for the divider unless the divisor is
// zero. A full result register held by the receiver adds its wait on top.
// The result register lets the next instruction be accepted while the previous
// result still waits. Overflow, underflow and divide by zero leave the stack
// unchanged and latch a fault; after a fault or halt every item returns the
// stopped status until reset. op_enable may only be written while idle.
module stack_machine_executor #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // op_enable register
  input  logic                          op_enable_we,
  input  logic [sme_pkg::EN_W-1:0]      op_enable_data,
  // instruction stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sme_pkg::S_TDATA_W-1:0] s_tdata,   // op[6:0], operand[38:7], 0
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sme_pkg::M_TDATA_W-1:0] m_tdata    // status[2:0], top_value[34:3],
                                                   // depth[43:35], show_valid[44],
                                                   // halted[45], 0
);

  localparam int DW  = sme_pkg::DATA_W;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  sme_pkg::state_t state, state_next;

  // instruction registers
  logic [sme_pkg::OP_W-1:0] op_r;
  logic [DW-1:0]            operand_r;
  sme_pkg::kind_t           kind_r, kind_c;

  // architectural state
  logic [SPW-1:0]           sp;
  logic [DW-1:0]            top;
  logic                     halt_r;
  logic                     fault_r;
  logic [sme_pkg::EN_W-1:0] op_enable_r;

  // stack RAM
  logic [DW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // pending commit
  logic [DW-1:0]            res_value,  res_value_next;
  logic [sme_pkg::ST_W-1:0] res_status, res_status_next;
  logic                     res_show,   res_show_next;
  logic [AW-1:0]            wr_addr,    wr_addr_next;
  logic [SPW-1:0]           sp_new,     sp_new_next;
  logic                     do_write,   do_write_next;
  logic                     set_halt,   set_halt_next;
  logic                     set_fault,  set_fault_next;

  // result register
  logic                        out_valid;
  logic [sme_pkg::ST_W-1:0]    out_status;
  logic [DW-1:0]               out_top;
  logic [sme_pkg::DEPTH_W-1:0] out_depth;
  logic                        out_show;
  logic                        out_halted;

  // misc control
  logic              stopped;
  logic              needs_pair;
  logic              out_free;
  logic              fin_go;
  logic [DW-1:0]     mul_x;
  logic [DW-1:0]     product;
  logic [DW-1:0]     fin_top;
  sme_pkg::div_req_t div_req;
  sme_pkg::div_rsp_t div_rsp;

  // decode
  assign kind_c     = sme_pkg::op_decode(op_r, op_enable_r);
  assign stopped    = halt_r | fault_r;
  assign needs_pair = !stopped && (sp >= SPW'(2)) &&
                      (kind_c inside {sme_pkg::K_ADD, sme_pkg::K_SUB,
                                      sme_pkg::K_MUL, sme_pkg::K_DIV});

  // shared multiplier: top*top for square, second*top for mul
  assign mul_x   = (state == sme_pkg::S_CHECK) ? top : rd_data;
  assign product = mul_x * top;

  assign rd_addr = AW'(sp - SPW'(2));

  sme_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sme_pkg::S_IDLE:  if (s_tvalid) state_next = sme_pkg::S_CHECK;
      sme_pkg::S_CHECK: state_next = needs_pair ? sme_pkg::S_ARITH : sme_pkg::S_FIN;
      sme_pkg::S_ARITH: begin
        if (kind_r == sme_pkg::K_DIV && top != '0) state_next = sme_pkg::S_DIV;
        else state_next = sme_pkg::S_FIN;
      end
      sme_pkg::S_DIV:   if (div_rsp.done) state_next = sme_pkg::S_FIN;
      sme_pkg::S_FIN:   if (out_free) state_next = sme_pkg::S_IDLE;
      default:          state_next = sme_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready         = (state == sme_pkg::S_IDLE);
    out_free         = !out_valid || m_tready;
    fin_go           = (state == sme_pkg::S_FIN) && out_free;
    mem_we           = fin_go && do_write;
    div_req.start    = (state == sme_pkg::S_ARITH) && (kind_r == sme_pkg::K_DIV) &&
                       (top != '0);
    div_req.dividend = rd_data;
    div_req.divisor  = top;
  end

  // build the commit for the current instruction
  always_comb begin
    res_value_next  = res_value;
    res_status_next = res_status;
    res_show_next   = res_show;
    wr_addr_next    = wr_addr;
    sp_new_next     = sp_new;
    do_write_next   = do_write;
    set_halt_next   = set_halt;
    set_fault_next  = set_fault;
    case (state)
      sme_pkg::S_CHECK: begin
        res_status_next = sme_pkg::ST_OK;
        res_show_next   = 1'b0;
        sp_new_next     = sp;
        do_write_next   = 1'b0;
        set_halt_next   = 1'b0;
        set_fault_next  = 1'b0;
        if (stopped) begin
          res_status_next = sme_pkg::ST_STOP;
        end else begin
          case (kind_c)
            sme_pkg::K_PUSH: begin
              if (sp >= SP_FULL) begin
                res_status_next = sme_pkg::ST_OVER;
                set_fault_next  = 1'b1;
              end else begin
                res_value_next = operand_r;
                wr_addr_next   = AW'(sp);
                sp_new_next    = sp + SPW'(1);
                do_write_next  = 1'b1;
              end
            end
            sme_pkg::K_ADD, sme_pkg::K_SUB, sme_pkg::K_MUL, sme_pkg::K_DIV: begin
              if (sp < SPW'(2)) begin
                res_status_next = sme_pkg::ST_UNDER;
                set_fault_next  = 1'b1;
              end else begin
                wr_addr_next  = AW'(sp - SPW'(2));
                sp_new_next   = sp - SPW'(1);
                do_write_next = 1'b1;
              end
            end
            sme_pkg::K_PRINT: begin
              if (sp == '0) begin
                res_status_next = sme_pkg::ST_UNDER;
                set_fault_next  = 1'b1;
              end else begin
                res_show_next = 1'b1;
              end
            end
            sme_pkg::K_HALT: set_halt_next = 1'b1;
            sme_pkg::K_SQUARE: begin
              if (sp == '0) begin
                res_status_next = sme_pkg::ST_UNDER;
                set_fault_next  = 1'b1;
              end else begin
                res_value_next = product;
                wr_addr_next   = AW'(sp - SPW'(1));
                do_write_next  = 1'b1;
              end
            end
            default: res_status_next = sme_pkg::ST_BADOP;
          endcase
        end
      end
      sme_pkg::S_ARITH: begin
        case (kind_r)
          sme_pkg::K_ADD: res_value_next = rd_data + top;
          sme_pkg::K_SUB: res_value_next = rd_data - top;
          sme_pkg::K_MUL: res_value_next = product;
          sme_pkg::K_DIV: begin
            if (top == '0) begin
              res_status_next = sme_pkg::ST_DIVZ;
              set_fault_next  = 1'b1;
              do_write_next   = 1'b0;
              sp_new_next     = sp;
            end
          end
          default: res_value_next = res_value;
        endcase
      end
      sme_pkg::S_DIV: if (div_rsp.done) res_value_next = div_rsp.quotient;
      default: res_value_next = res_value;
    endcase
  end

  // top of stack as seen after the commit
  assign fin_top = do_write ? res_value : top;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sme_pkg::S_IDLE;
      sp          <= '0;
      halt_r      <= 1'b0;
      fault_r     <= 1'b0;
      op_enable_r <= '1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (op_enable_we) op_enable_r <= op_enable_data;
      if (fin_go) begin
        sp        <= sp_new;
        halt_r    <= halt_r | set_halt;
        fault_r   <= fault_r | set_fault;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      op_r      <= s_tdata[sme_pkg::OP_W-1:0];
      operand_r <= s_tdata[sme_pkg::OP_W +: DW];
    end
    if (state == sme_pkg::S_CHECK) kind_r <= kind_c;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_show   <= res_show_next;
    wr_addr    <= wr_addr_next;
    sp_new     <= sp_new_next;
    do_write   <= do_write_next;
    set_halt   <= set_halt_next;
    set_fault  <= set_fault_next;
    if (mem_we) top <= res_value;
    if (fin_go) begin
      out_status <= res_status;
      out_top    <= (sp_new != '0) ? fin_top : '0;
      out_depth  <= sme_pkg::DEPTH_W'(sp_new);
      out_show   <= res_show;
      out_halted <= halt_r | set_halt;
    end
  end

  // stack RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= res_value;
    if (state == sme_pkg::S_CHECK) rd_data <= mem[rd_addr];
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_halted, out_show, out_depth, out_top, out_status};

endmodule

FILE: rtl/sme_checker.sv
`include "stack_machine_executor_macros.svh"

// Port-level checks for the stack machine executor.
module sme_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sme_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [sme_pkg::ST_W-1:0]    status;
  logic [sme_pkg::DATA_W-1:0]  top_value;
  logic [sme_pkg::DEPTH_W-1:0] depth;
  logic                        show_valid;
  logic                        halted;
  logic                        stop_seen;

  assign status     = m_tdata[2:0];
  assign top_value  = m_tdata[34:3];
  assign depth      = m_tdata[43:35];
  assign show_valid = m_tdata[44];
  assign halted     = m_tdata[45];

  // a delivered fault or halt stops the machine for good
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_seen <= 1'b0;
    end else if (m_tvalid && m_tready &&
                 (halted || status == sme_pkg::ST_OVER ||
                  status == sme_pkg::ST_UNDER || status == sme_pkg::ST_DIVZ)) begin
      stop_seen <= 1'b1;
    end
  end

  `SME_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
  `SME_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `SME_ASSERT_SAME(a_stay_stopped, m_tvalid && stop_seen, status == sme_pkg::ST_STOP, "result after stop not stopped")
  `SME_ASSERT_SAME(a_show_ok, m_tvalid && show_valid, status == sme_pkg::ST_OK && depth != '0, "print shown on failed step")
  `SME_ASSERT_SAME(a_empty_zero, m_tvalid && depth == '0, top_value == '0, "empty stack with nonzero top")

endmodule

bind stack_machine_executor sme_checker u_sme_checker (.*);

FILE: dv/stack_machine_executor_tb.sv
module stack_machine_executor_tb;
  import sme_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int STACK_DEPTH      = STACK_DEPTH_DEF;
  localparam int SETTLE_CYCLES    = 48;      // longer than one divide
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TIMEOUT_CYCLES   = 800000;

  localparam logic [DATA_W-1:0] MIN_INT  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MAX_INT  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [DATA_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
    logic               show;
    logic               halted;
  } stack_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] operand;
    bit                pinned;
    stack_result_t     want;
  } instr_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 op_enable_we;
  logic [EN_W-1:0]      op_enable_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // op[6:0], operand[38:7], 0
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // status[2:0], top_value[34:3], depth[43:35],
                                   // show_valid[44], halted[45], 0

  // typed-in expectation travelling with the current instruction beat
  logic          pin_valid;
  stack_result_t pin_result;

  // shadow machine state
  logic [DATA_W-1:0]  shadow_stack [STACK_DEPTH];
  logic [DEPTH_W-1:0] shadow_sp;
  bit                 shadow_halted;
  bit                 shadow_faulted;
  logic [EN_W-1:0]    shadow_enable;

  stack_result_t expected_results[$];
  instr_row_t    directed_rows[$];

  int  idle_pct;
  bit  long_hold;
  int  n_errors;
  int  n_accepted;
  int  n_results;
  int  n_divides;
  int  n_prints;
  int  n_stopped;
  int  n_enable_writes;
  int  deepest;

  always #(CLK_PERIOD / 2) clk = ~clk;

  stack_machine_executor #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .op_enable_we  (op_enable_we),
    .op_enable_data(op_enable_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

  // ---------------------------------------------------------------------
  // Instruction semantics
  // ---------------------------------------------------------------------

  function automatic int enable_bit(logic [OP_W-1:0] op);
    case (op)
      OP_PUSH: return EN_PUSH;
      OP_ADD:  return EN_ADD;
      OP_SUB:  return EN_SUB;
      OP_MUL:  return EN_MUL;
      OP_DIV:  return EN_DIV;
      OP_PEEK: return EN_PRINT;
      OP_HALT: return EN_HALT;
      OP_SQR:  return EN_SQUARE;
      default: return -1;
    endcase
  endfunction

  // status an instruction would get from the current shadow state
  function automatic logic [ST_W-1:0] classify_instr(logic [OP_W-1:0] op);
    int b;
    b = enable_bit(op);
    if (shadow_halted || shadow_faulted) return ST_STOP;
    if (b < 0 || !shadow_enable[b]) return ST_BADOP;
    case (op)
      OP_PUSH:
        return (shadow_sp >= STACK_DEPTH) ? ST_OVER : ST_OK;
      OP_ADD, OP_SUB, OP_MUL:
        return (shadow_sp < 2) ? ST_UNDER : ST_OK;
      OP_DIV: begin
        if (shadow_sp < 2) return ST_UNDER;
        if (shadow_stack[shadow_sp - 1] == '0) return ST_DIVZ;
        return ST_OK;
      end
      OP_PEEK, OP_SQR:
        return (shadow_sp < 1) ? ST_UNDER : ST_OK;
      default:
        return ST_OK;
    endcase
  endfunction

  // signed divide truncating toward zero, done on magnitudes so that
  // the most negative value over -1 wraps
  function automatic logic [DATA_W-1:0] div_trunc(logic [DATA_W-1:0] a,
                                                  logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] q;
    ma = a[DATA_W-1] ? (32'd0 - a) : a;
    mb = b[DATA_W-1] ? (32'd0 - b) : b;
    q  = ma / mb;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? (32'd0 - q) : q;
  endfunction

  // executes one instruction on the shadow state, returns the result beat
  function automatic stack_result_t execute_instr(logic [OP_W-1:0]   op,
                                                  logic [DATA_W-1:0] operand);
    stack_result_t     r;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] val;
    r = '0;
    r.status = classify_instr(op);
    if (r.status == ST_OK) begin
      case (op)
        OP_PUSH: begin
          shadow_stack[shadow_sp] = operand;
          shadow_sp++;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          lhs = shadow_stack[shadow_sp - 2];
          rhs = shadow_stack[shadow_sp - 1];
          case (op)
            OP_ADD:  val = lhs + rhs;
            OP_SUB:  val = lhs - rhs;
            OP_MUL:  val = lhs * rhs;
            default: val = div_trunc(lhs, rhs);
          endcase
          shadow_sp--;
          shadow_stack[shadow_sp - 1] = val;
        end
        OP_PEEK: r.show = 1'b1;
        OP_HALT: shadow_halted = 1'b1;
        default: begin
          val = shadow_stack[shadow_sp - 1];
          shadow_stack[shadow_sp - 1] = val * val;
        end
      endcase
    end else if (r.status inside {ST_OVER, ST_UNDER, ST_DIVZ}) begin
      shadow_faulted = 1'b1;
    end
    r.top    = (shadow_sp != 0) ? shadow_stack[shadow_sp - 1] : '0;
    r.depth  = shadow_sp;
    r.halted = shadow_halted;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
    n_errors++;
    $display("[%0t] result %0d: %s expected %0h got %0h",
             $time, n_results, what, want, got);
  endtask

  always @(posedge clk) begin : scoreboard
    stack_result_t want;
    stack_result_t got;
    if (!rst) begin
      if (op_enable_we) shadow_enable = op_enable_data;

      // instruction beat: advance the shadow machine
      if (s_tvalid && s_tready) begin
        want = execute_instr(s_tdata[OP_W-1:0], s_tdata[OP_W +: DATA_W]);
        if (s_tdata[OP_W-1:0] == OP_DIV && want.status == ST_OK) n_divides++;
        if (want.show) n_prints++;
        if (want.status == ST_STOP) n_stopped++;
        if (shadow_sp > deepest) deepest = shadow_sp;
        if (pin_valid) want = pin_result;
        expected_results.push_back(want);
        n_accepted++;
      end

      // result beat: compare against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.top    = m_tdata[34:3];
        got.depth  = m_tdata[43:35];
        got.show   = m_tdata[44];
        got.halted = m_tdata[45];
        n_results++;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected beat, status", '0, DATA_W'(got.status));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
          if (got.top !== want.top)
            flag_mismatch("top_value", want.top, got.top);
          if (got.depth !== want.depth)
            flag_mismatch("depth", DATA_W'(want.depth), DATA_W'(got.depth));
          if (got.show !== want.show)
            flag_mismatch("show_valid", DATA_W'(want.show), DATA_W'(got.show));
          if (got.halted !== want.halted)
            flag_mismatch("halted", DATA_W'(want.halted), DATA_W'(got.halted));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result sink: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int held;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        for (held = 0; held < LONG_HOLD_CYCLES; held++) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Instruction source helpers (all entered and left at a falling edge)
  // ---------------------------------------------------------------------

  task automatic send_instr(logic [OP_W-1:0] op, logic [DATA_W-1:0] operand,
                            bit pinned, stack_result_t want);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= {1'b0, operand, op};
    pin_valid  <= pinned;
    pin_result <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_random(logic [OP_W-1:0] op, logic [DATA_W-1:0] operand);
    send_instr(op, operand, 1'b0, '0);
  endtask

  // wait until every expected result has come back, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_op_enable(logic [EN_W-1:0] value);
    op_enable_we   <= 1'b1;
    op_enable_data <= value;
    @(negedge clk);
    op_enable_we   <= 1'b0;
    @(negedge clk);
    n_enable_writes++;
  endtask

  task automatic add_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] operand, bit pinned,
                         logic [ST_W-1:0] st, logic [DATA_W-1:0] top,
                         logic [DEPTH_W-1:0] dep, logic shw);
    instr_row_t r;
    r.op          = op;
    r.operand     = operand;
    r.pinned      = pinned;
    r.want.status = st;
    r.want.top    = top;
    r.want.depth  = dep;
    r.want.show   = shw;
    r.want.halted = 1'b0;
    directed_rows.push_back(r);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 16) - 8;
      1: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 32'd1;
          2:       return ALL_ONES;
          3:       return MIN_INT;
          default: return MAX_INT;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_unknown_op();
    logic [OP_W-1:0] v;
    do v = OP_W'($urandom_range(0, 127)); while (enable_bit(v) >= 0);
    return v;
  endfunction

  // would this opcode stop the machine for the rest of the run
  function automatic bit ends_run(logic [OP_W-1:0] op);
    logic [ST_W-1:0] s;
    s = classify_instr(op);
    return (s inside {ST_OVER, ST_UNDER, ST_DIVZ}) || (s == ST_OK && op == OP_HALT);
  endfunction

  // one random instruction steering the stack toward a target depth,
  // never letting the machine stop
  task automatic random_instr(int depth_goal);
    logic [OP_W-1:0] op;
    if ($urandom_range(0, 99) < 8) begin
      op = OP_W'($urandom_range(0, 127));
    end else if (shadow_sp < depth_goal && $urandom_range(0, 9) < 7) begin
      op = OP_PUSH;
    end else begin
      case ($urandom_range(0, 7))
        0:       op = OP_ADD;
        1:       op = OP_SUB;
        2:       op = OP_MUL;
        3:       op = OP_DIV;
        4:       op = OP_PEEK;
        5:       op = OP_SQR;
        6:       op = OP_PUSH;
        default: op = OP_HALT;
      endcase
    end
    if (ends_run(op)) op = ends_run(OP_PUSH) ? pick_unknown_op() : OP_PUSH;
    push_random(op, pick_operand());
  endtask

  // ---------------------------------------------------------------------
  // Run limit
  // ---------------------------------------------------------------------

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL stack_machine_executor");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin : stimulus
    logic [EN_W-1:0] phase_enable [7];
    int              phase_items  [7];
    int              depth_goal;
    int              ending_kind;
    string           ending;

    rst            = 1'b1;
    op_enable_we   = 1'b0;
    op_enable_data = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    pin_valid      = 1'b0;
    pin_result     = '0;
    idle_pct       = 0;
    long_hold      = 1'b0;
    n_errors       = 0;
    n_accepted     = 0;
    n_results      = 0;
    n_divides      = 0;
    n_prints       = 0;
    n_stopped      = 0;
    n_enable_writes = 0;
    deepest        = 0;
    shadow_sp      = '0;
    shadow_halted  = 1'b0;
    shadow_faulted = 1'b0;
    shadow_enable  = '1;
    foreach (shadow_stack[i]) shadow_stack[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: unknown opcodes, wrapping arithmetic, division rounding
    // and the most negative value over -1; stopping cases come at the end
    add_row('0,             '0,            1, ST_BADOP, '0, 0, 0);
    add_row('1,             ALL_ONES,      1, ST_BADOP, '0, 0, 0);
    add_row(OP_HALT + 7'd1, 32'h5555_5555, 1, ST_BADOP, '0, 0, 0);
    add_row(OP_SQR - 7'd1,  32'hAAAA_AAAA, 1, ST_BADOP, '0, 0, 0);
    add_row(OP_SQR + 7'd1,  '0,            1, ST_BADOP, '0, 0, 0);
    add_row(OP_PUSH, MAX_INT,        1, ST_OK, MAX_INT,  1, 0);
    add_row(OP_PUSH, 32'd1,          1, ST_OK, 32'd1,    2, 0);
    add_row(OP_ADD,  32'hDEAD_BEEF,  1, ST_OK, MIN_INT,  1, 0);
    add_row(OP_PUSH, ALL_ONES,       1, ST_OK, ALL_ONES, 2, 0);
    add_row(OP_DIV,  32'hDEAD_BEEF,  1, ST_OK, MIN_INT,  1, 0);
    add_row(OP_PEEK, ALL_ONES,       1, ST_OK, MIN_INT,  1, 1);
    add_row(OP_SQR,  32'h1234_5678,  1, ST_OK, '0,       1, 0);
    add_row(OP_PUSH, MIN_INT,        1, ST_OK, MIN_INT,  2, 0);
    add_row(OP_SUB,  ALL_ONES,       1, ST_OK, MIN_INT,  1, 0);
    add_row(OP_PUSH, 32'd7,          1, ST_OK, 32'd7,    2, 0);
    add_row(OP_PUSH, 32'hFFFF_FFFE,  1, ST_OK, 32'hFFFF_FFFE, 3, 0);
    add_row(OP_DIV,  '0,             1, ST_OK, 32'hFFFF_FFFD, 2, 0);
    add_row(OP_MUL,  MAX_INT,        0, ST_OK, '0, 0, 0);
    add_row(OP_PUSH, 32'hFFFF_FFF9,  0, ST_OK, '0, 0, 0);
    add_row(OP_PUSH, 32'd2,          0, ST_OK, '0, 0, 0);
    add_row(OP_DIV,  '0,             1, ST_OK, 32'hFFFF_FFFD, 2, 0);
    add_row(OP_PUSH, 32'h1234_5678,  0, ST_OK, '0, 0, 0);
    add_row(OP_SQR,  '0,             0, ST_OK, '0, 0, 0);
    add_row(OP_PEEK, '0,             0, ST_OK, '0, 0, 0);
    add_row(OP_PUSH, '0,             0, ST_OK, '0, 0, 0);
    add_row(OP_MUL,  ALL_ONES,       0, ST_OK, '0, 0, 0);

    idle_pct = 20;
    foreach (directed_rows[i])
      send_instr(directed_rows[i].op, directed_rows[i].operand,
                 directed_rows[i].pinned, directed_rows[i].want);
    drain_results();

    // random phases, each under its own opcode enable mask
    phase_enable[0] = '1;
    phase_enable[1] = '0;
    for (int p = 2; p < 6; p++) phase_enable[p] = EN_W'($urandom_range(0, 255));
    phase_enable[6] = '1;
    phase_items = '{120, 30, 100, 100, 100, 100, 120};

    for (int p = 0; p < 7; p++) begin
      write_op_enable(phase_enable[p]);
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      depth_goal = $urandom_range(0, 24);

      // fill to the brim once, then work on a full stack
      if (p == 0)
        while (shadow_sp < STACK_DEPTH) push_random(OP_PUSH, pick_operand());

      // receiver stalls for a long stretch while instructions keep coming
      if (p == 6) begin
        idle_pct  = 0;
        long_hold = 1'b1;
      end

      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(0, 49) == 0)
          depth_goal = ($urandom_range(0, 3) == 0) ? $urandom_range(0, STACK_DEPTH)
                                                    : $urandom_range(0, 24);
        random_instr(depth_goal);
      end
      drain_results();
    end

    // last part, no idling: stop the machine one way, then check it stays stopped
    write_op_enable('1);
    idle_pct    = 0;
    ending_kind = $urandom_range(0, 3);
    case (ending_kind)
      0: begin
        ending = "halt";
        push_random(OP_HALT, pick_operand());
      end
      1: begin
        ending = "underflow";
        while (shadow_sp > 1) push_random(OP_ADD, pick_operand());
        if (shadow_sp == 0) begin
          case ($urandom_range(0, 2))
            0:       push_random(OP_PEEK, pick_operand());
            1:       push_random(OP_SQR, pick_operand());
            default: push_random(OP_ADD, pick_operand());
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0:       push_random(OP_ADD, pick_operand());
            1:       push_random(OP_SUB, pick_operand());
            2:       push_random(OP_MUL, pick_operand());
            default: push_random(OP_DIV, pick_operand());
          endcase
        end
      end
      2: begin
        ending = "divide by zero";
        if (shadow_sp == STACK_DEPTH) push_random(OP_ADD, pick_operand());
        if (shadow_sp == 0) push_random(OP_PUSH, pick_operand());
        push_random(OP_PUSH, '0);
        push_random(OP_DIV, pick_operand());
      end
      default: begin
        ending = "overflow";
        while (shadow_sp < STACK_DEPTH) push_random(OP_PUSH, $urandom);
        push_random(OP_PUSH, $urandom);
      end
    endcase
    repeat (8) push_random(OP_W'($urandom_range(0, 127)), $urandom);
    drain_results();

    $display("ran %0d instructions, %0d results: %0d divides, %0d prints, deepest stack %0d",
             n_accepted, n_results, n_divides, n_prints, deepest);
    $display("%0d enable masks written; stopped by %s, then %0d beats answered as stopped",
             n_enable_writes, ending, n_stopped);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS stack_machine_executor");
    end else begin
      $display("FAIL stack_machine_executor");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sme_pkg.sv
rtl/sme_div.sv
rtl/stack_machine_executor.sv
rtl/sme_checker.sv
dv/stack_machine_executor_tb.sv
